@@ rtl/core/hsog_pkg.sv @@
// ----------------------------------------------------------------------------
// hsog_pkg: shared types and constants of the Hilbert scan offset generator
// Holds field widths, configuration register indexes, controller states and
// the two-state child table of the curve walk.
// ----------------------------------------------------------------------------
package hsog_pkg;

  localparam int CFG_W = 11;  // configuration data width
  localparam int OFS_W = 20;  // cell_offset width
  localparam int COL_W = 10;  // cell_col width
  localparam int ROW_W = 10;  // cell_row width

  typedef enum logic [0:0] {
    REG_ARRAY_WIDTH  = 1'b0,
    REG_ARRAY_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] child;    // quadrant before corner rotation
    logic [1:0] ncorner;  // entry corner of the child, before rotation
    logic       nflip;    // flip bit of the child
  } child_t;

  // Child table indexed by flip bit and base-4 digit.
  function automatic child_t child_lookup(input logic flip, input logic [1:0] digit);
    child_t res;
    res = '{child: 2'd0, ncorner: 2'd0, nflip: 1'b0};
    case ({flip, digit})
      3'b0_00: res = '{child: 2'd0, ncorner: 2'd0, nflip: 1'b1};
      3'b0_01: res = '{child: 2'd2, ncorner: 2'd0, nflip: 1'b0};
      3'b0_10: res = '{child: 2'd3, ncorner: 2'd0, nflip: 1'b0};
      3'b0_11: res = '{child: 2'd1, ncorner: 2'd3, nflip: 1'b1};
      3'b1_00: res = '{child: 2'd0, ncorner: 2'd0, nflip: 1'b0};
      3'b1_01: res = '{child: 2'd1, ncorner: 2'd0, nflip: 1'b1};
      3'b1_10: res = '{child: 2'd3, ncorner: 2'd0, nflip: 1'b1};
      3'b1_11: res = '{child: 2'd2, ncorner: 2'd3, nflip: 1'b0};
      default: res = '{child: 2'd0, ncorner: 2'd0, nflip: 1'b0};
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/hilbert_scan_offset_generator.sv @@
// ----------------------------------------------------------------------------
// hilbert_scan_offset_generator: Hilbert-order cell offset generator
// Walks the cells of an array_width x array_height array in Hilbert curve
// order and returns one row-major offset per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_restart): each transfer is a request
//   for the next cell; in_restart=1 rewinds the scan to the curve start first.
//   Output channel (out_valid/out_ready): one result per request with the
//   offset row*width+col, the column, the row, is_last on the final cell and
//   exhausted (all other fields zero) once no cell remains.
//   Configuration (cfg_we/cfg_index/cfg_wdata): width and height, written
//   while the block is idle; values above 2^MAX_LOG2_SIDE saturate.
// Timing:
//   Each curve position is decoded one base-4 digit per cycle, one digit per
//   curve level (log2 of the covering square side). A request runs two
//   searches: the cell to emit and the lookahead for the next one, each
//   testing candidates in curve order until one lands inside the array or
//   the search runs off the curve end.
//   One request is in flight at a time; the result sits in an output register,
//   so the next request is taken while it waits for out_ready.
// Reset: scan rewinds to position 0, width 640, height 480, no result pending.
// ----------------------------------------------------------------------------
module hilbert_scan_offset_generator #(
  parameter int MAX_LOG2_SIDE = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [hsog_pkg::CFG_W-1:0]  cfg_wdata,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsog_pkg::OFS_W-1:0]  out_cell_offset,
  output logic [hsog_pkg::COL_W-1:0]  out_cell_col,
  output logic [hsog_pkg::ROW_W-1:0]  out_cell_row,
  output logic                        out_is_last,
  output logic                        out_exhausted
);

  localparam int SIDE_W = MAX_LOG2_SIDE;                 // column / row bits
  localparam int DIG_W  = 2 * MAX_LOG2_SIDE;             // digit shift register
  localparam int POS_W  = 2 * MAX_LOG2_SIDE + 1;         // holds one past the end
  localparam int DIM_W  = (MAX_LOG2_SIDE + 1 > hsog_pkg::CFG_W) ?
                          MAX_LOG2_SIDE + 1 : hsog_pkg::CFG_W;
  localparam int LVL_W  = $clog2(MAX_LOG2_SIDE + 1);
  localparam int PROD_W = SIDE_W + DIM_W + 1;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(1) << MAX_LOG2_SIDE;

  // configuration
  logic [hsog_pkg::CFG_W-1:0] width_cfg_r, height_cfg_r;

  // control state
  hsog_pkg::state_t state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;        // next candidate curve position
  logic             done_r, done_nxt;      // scan finished
  logic             out_valid_r, out_valid_nxt;

  // per-request working registers
  logic [DIM_W-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [POS_W-1:0]  cand_r, cand_nxt;     // candidate under test
  logic [POS_W-1:0]  p_r, p_nxt;           // position being emitted
  logic              phase_r, phase_nxt;   // 0: find cell, 1: lookahead
  logic [DIG_W-1:0]  sh_r, sh_nxt;         // digits, top digit in the MSBs
  logic [LVL_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        corner_r, corner_nxt;
  logic              flip_r, flip_nxt;
  logic [SIDE_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [SIDE_W-1:0] res_col_r, res_col_nxt, res_row_r, res_row_nxt;
  logic              res_last_r, res_last_nxt, res_exh_r, res_exh_nxt;

  // output register
  logic [hsog_pkg::OFS_W-1:0] out_ofs_r;
  logic [hsog_pkg::COL_W-1:0] out_col_r;
  logic [hsog_pkg::ROW_W-1:0] out_row_r;
  logic                       out_last_r, out_exh_r;

  // combinational helpers
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [LVL_W-1:0]   lvl_calc;
  logic               beyond;
  logic               in_bounds;
  logic               emit_load;
  logic [PROD_W-1:0]  ofs_full;
  hsog_pkg::child_t   tab;
  logic [1:0]         child;

  assign in_ready  = (state_r == hsog_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_cell_offset = out_ofs_r;
  assign out_cell_col    = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_is_last     = out_last_r;
  assign out_exhausted   = out_exh_r;

  // Saturate dimensions and find the smallest covering level count.
  always_comb begin
    w_eff = (DIM_W'(width_cfg_r)  > DIM_CAP) ? DIM_CAP : DIM_W'(width_cfg_r);
    h_eff = (DIM_W'(height_cfg_r) > DIM_CAP) ? DIM_CAP : DIM_W'(height_cfg_r);
    lvl_calc = LVL_W'(MAX_LOG2_SIDE);
    for (int l = MAX_LOG2_SIDE; l >= 0; l--) begin
      if (((DIM_W'(1) << l) >= w_eff) && ((DIM_W'(1) << l) >= h_eff)) begin
        lvl_calc = LVL_W'(l);
      end
    end
  end

  // Candidate past the end of the curve: any bit at or above 2*levels set.
  assign beyond    = (cand_r >> {lvl_r, 1'b0}) != '0;
  assign in_bounds = (DIM_W'(col_r) < w_r) && (DIM_W'(row_r) < h_r);
  assign tab       = hsog_pkg::child_lookup(flip_r, sh_r[DIG_W-1 -: 2]);
  assign child     = tab.child ^ corner_r;
  assign emit_load = (state_r == hsog_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  assign ofs_full  = PROD_W'(res_row_r) * PROD_W'(w_r) + PROD_W'(res_col_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    lvl_nxt       = lvl_r;
    cand_nxt      = cand_r;
    p_nxt         = p_r;
    phase_nxt     = phase_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    corner_nxt    = corner_r;
    flip_nxt      = flip_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    res_col_nxt   = res_col_r;
    res_row_nxt   = res_row_r;
    res_last_nxt  = res_last_r;
    res_exh_nxt   = res_exh_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      hsog_pkg::ST_IDLE: begin
        if (in_valid) begin
          // Latch dimensions and level count for the whole request.
          w_nxt        = w_eff;
          h_nxt        = h_eff;
          lvl_nxt      = lvl_calc;
          res_last_nxt = 1'b0;
          res_exh_nxt  = 1'b0;
          pos_nxt      = in_restart ? '0 : pos_r;
          done_nxt     = in_restart ? 1'b0 : done_r;
          if (done_nxt || (w_eff == '0) || (h_eff == '0)) begin
            done_nxt    = 1'b1;
            res_exh_nxt = 1'b1;
            state_nxt   = hsog_pkg::ST_EMIT;
          end else begin
            cand_nxt  = pos_nxt;
            phase_nxt = 1'b0;
            state_nxt = hsog_pkg::ST_LOAD;
          end
        end
      end

      hsog_pkg::ST_LOAD: begin
        if (beyond) begin
          if (!phase_r) begin
            // no cell left from the stored position
            done_nxt    = 1'b1;
            res_exh_nxt = 1'b1;
          end else begin
            // emitted cell was the final one
            pos_nxt      = p_r + POS_W'(1);
            done_nxt     = 1'b1;
            res_last_nxt = 1'b1;
          end
          state_nxt = hsog_pkg::ST_EMIT;
        end else begin
          // Align the top digit of this curve size with the MSBs.
          sh_nxt     = cand_r[DIG_W-1:0] << {(LVL_W'(MAX_LOG2_SIDE) - lvl_r), 1'b0};
          cnt_nxt    = lvl_r;
          corner_nxt = 2'd0;
          flip_nxt   = 1'b0;
          col_nxt    = '0;
          row_nxt    = '0;
          state_nxt  = (lvl_r == '0) ? hsog_pkg::ST_CHECK : hsog_pkg::ST_WALK;
        end
      end

      hsog_pkg::ST_WALK: begin
        // One level per cycle: shift in one column bit and one row bit.
        corner_nxt = tab.ncorner ^ corner_r;
        flip_nxt   = tab.nflip;
        col_nxt    = (col_r << 1) | SIDE_W'(child[0]);
        row_nxt    = (row_r << 1) | SIDE_W'(child[1]);
        sh_nxt     = sh_r << 2;
        cnt_nxt    = cnt_r - LVL_W'(1);
        if (cnt_r == LVL_W'(1)) begin
          state_nxt = hsog_pkg::ST_CHECK;
        end
      end

      hsog_pkg::ST_CHECK: begin
        if (in_bounds && !phase_r) begin
          // found the cell to emit; start the lookahead after it
          p_nxt       = cand_r;
          res_col_nxt = col_r;
          res_row_nxt = row_r;
          cand_nxt    = cand_r + POS_W'(1);
          phase_nxt   = 1'b1;
          state_nxt   = hsog_pkg::ST_LOAD;
        end else if (in_bounds) begin
          pos_nxt   = cand_r;
          state_nxt = hsog_pkg::ST_EMIT;
        end else begin
          cand_nxt  = cand_r + POS_W'(1);
          state_nxt = hsog_pkg::ST_LOAD;
        end
      end

      hsog_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = hsog_pkg::ST_IDLE;
        end
      end

      default: state_nxt = hsog_pkg::ST_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hsog_pkg::ST_IDLE;
      pos_r        <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      width_cfg_r  <= hsog_pkg::CFG_W'(640);
      height_cfg_r <= hsog_pkg::CFG_W'(480);
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (hsog_pkg::cfg_reg_t'(cfg_index))
          hsog_pkg::REG_ARRAY_WIDTH:  width_cfg_r  <= cfg_wdata;
          hsog_pkg::REG_ARRAY_HEIGHT: height_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    lvl_r      <= lvl_nxt;
    cand_r     <= cand_nxt;
    p_r        <= p_nxt;
    phase_r    <= phase_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    corner_r   <= corner_nxt;
    flip_r     <= flip_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    res_col_r  <= res_col_nxt;
    res_row_r  <= res_row_nxt;
    res_last_r <= res_last_nxt;
    res_exh_r  <= res_exh_nxt;
    if (emit_load) begin
      out_ofs_r  <= res_exh_r ? '0 : hsog_pkg::OFS_W'(ofs_full);
      out_col_r  <= res_exh_r ? '0 : hsog_pkg::COL_W'(res_col_r);
      out_row_r  <= res_exh_r ? '0 : hsog_pkg::ROW_W'(res_row_r);
      out_last_r <= res_exh_r ? 1'b0 : res_last_r;
      out_exh_r  <= res_exh_r;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: Hilbert scan offset generator testbench
// Drives requests into hilbert_scan_offset_generator, predicts each cell
// from its own curve walk over the configured array, and checks every
// result transfer field by field. Directed cases come first, then random
// scans under several sender and receiver throttling mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_LOG2_SIDE = 10;
  localparam int ITEMS_PER_PHASE = 312;
  // Cycles to hold after the last result before the next phase or the end.
  localparam int SETTLE_CYCLES = 2 * MAX_LOG2_SIDE + 8;
  localparam int MAX_REPORTS = 10;

  // Curve child table, indexed by {flip, digit}:
  // each entry is {quadrant[1:0], entry corner[1:0], next flip}.
  localparam logic [7:0][4:0] HILBERT_CHILD = {
    5'b10_11_0, 5'b11_00_1, 5'b01_00_1, 5'b00_00_0,
    5'b01_11_1, 5'b11_00_0, 5'b10_00_0, 5'b00_00_1
  };

  typedef struct packed {
    logic [hsog_pkg::OFS_W-1:0] offset;
    logic [hsog_pkg::COL_W-1:0] col;
    logic [hsog_pkg::ROW_W-1:0] row;
    logic                       is_last;
    logic                       exhausted;
  } scan_cell_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [0:0]                 cfg_index = hsog_pkg::REG_ARRAY_WIDTH;
  logic [hsog_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [hsog_pkg::OFS_W-1:0] out_cell_offset;
  logic [hsog_pkg::COL_W-1:0] out_cell_col;
  logic [hsog_pkg::ROW_W-1:0] out_cell_row;
  logic                       out_is_last;
  logic                       out_exhausted;

  // Shadow copy of the block's registers and scan state.
  int unsigned width_reg = 640;
  int unsigned height_reg = 480;
  int unsigned scan_pos = 0;
  bit          scan_finished = 1'b0;

  scan_cell_t  pending_cells[$];
  scan_cell_t  want_cell;
  scan_cell_t  got_cell;
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  hilbert_scan_offset_generator #(
    .MAX_LOG2_SIDE(MAX_LOG2_SIDE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_offset(out_cell_offset),
    .out_cell_col   (out_cell_col),
    .out_cell_row   (out_cell_row),
    .out_is_last    (out_is_last),
    .out_exhausted  (out_exhausted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Cell predictor
  // --------------------------------------------------------------------------

  // Saturate a dimension at the largest curve side.
  function automatic int unsigned clamp_dim(input int unsigned v);
    return (v > (1 << MAX_LOG2_SIDE)) ? (1 << MAX_LOG2_SIDE) : v;
  endfunction

  // Number of curve levels: log2 of the smallest square side covering w x h.
  function automatic int unsigned curve_levels(input int unsigned w, input int unsigned h);
    int unsigned lv;
    lv = 0;
    while (lv < MAX_LOG2_SIDE && ((1 << lv) < w || (1 << lv) < h)) lv++;
    return lv;
  endfunction

  // Walk the base-4 digits of a curve position from the top level down.
  function automatic void decode_position(input int unsigned pos, input int unsigned levels,
                                          output int unsigned col, output int unsigned row);
    logic [1:0] corner;
    logic [1:0] digit;
    logic [1:0] quad;
    logic       flip;
    logic [4:0] entry;
    int         lv;
    corner = 2'd0;
    flip = 1'b0;
    col = 0;
    row = 0;
    for (lv = int'(levels) - 1; lv >= 0; lv--) begin
      digit = 2'(pos >> (2 * lv));
      entry = HILBERT_CHILD[{flip, digit}];
      quad = entry[4:3] ^ corner;
      corner = entry[2:1] ^ corner;
      flip = entry[0];
      if (quad[0]) col |= (1 << lv);
      if (quad[1]) row |= (1 << lv);
    end
  endfunction

  // First curve position at or after start that lands inside the array.
  function automatic bit find_cell(input int unsigned start, w, h, levels,
                                   output int unsigned pos, col, row);
    int unsigned total;
    int unsigned p;
    int unsigned c;
    int unsigned r;
    total = 1 << (2 * levels);
    pos = 0;
    col = 0;
    row = 0;
    if (w == 0 || h == 0) return 1'b0;
    for (p = start; p < total; p++) begin
      decode_position(p, levels, c, r);
      if (c < w && r < h) begin
        pos = p;
        col = c;
        row = r;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the shadow scan by one request and queue the cell it yields.
  function automatic void predict_cell(input bit restart);
    scan_cell_t  pred;
    int unsigned w, h, lv, p, c, r, q, c2, r2;
    bit          hit;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    lv = curve_levels(w, h);
    if (restart) begin
      scan_pos = 0;
      scan_finished = 1'b0;
    end
    pred = '0;
    hit = 1'b0;
    if (!scan_finished) hit = find_cell(scan_pos, w, h, lv, p, c, r);
    if (!hit) begin
      scan_finished = 1'b1;
      pred.exhausted = 1'b1;
    end else begin
      pred.offset = hsog_pkg::OFS_W'(r * w + c);
      pred.col = hsog_pkg::COL_W'(c);
      pred.row = hsog_pkg::ROW_W'(r);
      // Look ahead for the following cell; none left means this one is last.
      if (find_cell(p + 1, w, h, lv, q, c2, r2)) begin
        scan_pos = q;
      end else begin
        scan_pos = p + 1;
        scan_finished = 1'b1;
        pred.is_last = 1'b1;
      end
    end
    pending_cells.push_back(pred);
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_cell = '{offset: out_cell_offset, col: out_cell_col, row: out_cell_row,
                   is_last: out_is_last, exhausted: out_exhausted};
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unrequested result: ofs=%0d col=%0d row=%0d last=%0b exh=%0b",
                   $realtime, got_cell.offset, got_cell.col, got_cell.row,
                   got_cell.is_last, got_cell.exhausted);
      end else begin
        want_cell = pending_cells.pop_front();
        if (got_cell !== want_cell) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] cell mismatch: exp ofs=%0d col=%0d row=%0d last=%0b exh=%0b, %s",
                     $realtime, want_cell.offset, want_cell.col, want_cell.row,
                     want_cell.is_last, want_cell.exhausted,
                     $sformatf("got ofs=%0d col=%0d row=%0d last=%0b exh=%0b",
                               got_cell.offset, got_cell.col, got_cell.row,
                               got_cell.is_last, got_cell.exhausted));
        end
      end
    end
  end

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Write one register; only called while nothing is in flight.
  task automatic write_reg(input hsog_pkg::cfg_reg_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= hsog_pkg::CFG_W'(value);
    @(posedge clk);
    case (idx)
      hsog_pkg::REG_ARRAY_WIDTH:  width_reg = value & 32'h7FF;
      hsog_pkg::REG_ARRAY_HEIGHT: height_reg = value & 32'h7FF;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input int unsigned w, input int unsigned h);
    write_reg(hsog_pkg::REG_ARRAY_WIDTH, w);
    write_reg(hsog_pkg::REG_ARRAY_HEIGHT, h);
  endtask

  // Send one request. Drop valid only when a gap is taken, so that
  // back-to-back requests keep valid high across the transfer edge.
  task automatic send_request(input bit restart);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cell(restart);
  endtask

  // Drop valid at the last transfer edge, then wait for every prediction
  // to be matched and let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Scan the 640 x 480 array the block comes up with.
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    drain_results();
  endtask

  // Whole scan of a tiny array: last flag, exhaustion after it, restart.
  task automatic test_full_scan_small();
    int i;
    set_dims(3, 2);
    send_request(1'b1);
    for (i = 0; i < 5; i++) send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_results();
  endtask

  // Single cell, saturated sides, largest legal sides, and zero sides.
  task automatic test_dimension_extremes();
    set_dims(1, 1);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();
    set_dims(2047, 2047);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();
    set_dims(1024, 512);
    send_request(1'b0);
    drain_results();
    set_dims(512, 1024);
    send_request(1'b0);
    drain_results();
    set_dims(0, 7);
    send_request(1'b1);
    drain_results();
    set_dims(5, 0);
    send_request(1'b1);
    drain_results();
  endtask

  // Resize in the middle of a scan: beyond the new curve, a finished scan
  // staying finished, and a scan that carries on in new dimensions.
  task automatic test_resize_mid_scan();
    int i;
    set_dims(8, 8);
    send_request(1'b1);
    for (i = 0; i < 3; i++) send_request(1'b0);
    drain_results();
    set_dims(2, 2);
    send_request(1'b0);
    drain_results();
    set_dims(8, 8);
    send_request(1'b0);
    send_request(1'b1);
    drain_results();
    set_dims(6, 5);
    send_request(1'b0);
    drain_results();
  endtask

  // Random scans over random arrays. Large arrays only see a few requests
  // near the curve start, where every position is a cell.
  task automatic test_random_scans(input int idle_pct, input int stall_pct);
    int          sent;
    int          i;
    int unsigned pick, w, h, area, batch;
    bit          keep;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      keep = 1'b0;
      if (pick < 70) begin
        w = $urandom_range(24, 1);
        h = $urandom_range(24, 1);
      end else if (pick < 80) begin
        // Thin strips make the search skip many outside positions.
        if ($urandom_range(1)) begin
          w = $urandom_range(3, 1);
          h = $urandom_range(32, 1);
        end else begin
          w = $urandom_range(32, 1);
          h = $urandom_range(3, 1);
        end
      end else if (pick < 88) begin
        if ($urandom_range(1)) begin
          w = 0;
          h = $urandom_range(24, 0);
        end else begin
          w = $urandom_range(24, 1);
          h = 0;
        end
      end else if (pick < 95) begin
        w = $urandom_range(2047, 512);
        h = $urandom_range(2047, 512);
      end else begin
        keep = 1'b1;
        w = width_reg;
        h = height_reg;
      end
      if (!keep) set_dims(w, h);
      area = clamp_dim(w) * clamp_dim(h);
      if (w > 64 || h > 64) batch = $urandom_range(4, 1);
      else batch = $urandom_range((area + 3 > 80) ? 80 : area + 3, 1);
      for (i = 0; i < int'(batch); i++) begin
        if (i == 0) send_request($urandom_range(9) < 7);
        else send_request($urandom_range(99) < 3);
      end
      sent += batch;
      drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_full_scan_small();
    test_dimension_extremes();
    test_resize_mid_scan();
    test_random_scans(0, 0);
    test_random_scans(84, 0);
    test_random_scans(0, 84);
    test_random_scans(36, 36);
    if (pending_cells.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #500ms;
    $display("[%0t] timeout", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
